>>> rtl/ubx_frame_receiver_top_assert.svh
// assertion macros for the ubx frame receiver
// included by ubx_frame_receiver_top, no other dependencies
`ifndef UBX_FRAME_RECEIVER_TOP_ASSERT_SVH
`define UBX_FRAME_RECEIVER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define UFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define UFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define UFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/ubx_fr_pkg.sv
// types and constants of the ubx frame receiver
// no dependencies, used by ubx_frame_receiver_top
`default_nettype none

package ubx_fr_pkg;

    localparam int PAYLOAD_BYTES_DEF = 255;

    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 48;
    localparam int M_USER_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h62;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_FIRST  = 1'b0,
        CFG_SYNC_SECOND = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REQ_BYTE  = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2,
        ST_DROP = 2'd3
    } t_status;

    typedef enum logic [8:0] {
        PH_HUNT    = 9'b000000001,
        PH_SYNC1   = 9'b000000010,
        PH_SYNC2   = 9'b000000100,
        PH_CLASS   = 9'b000001000,
        PH_ID      = 9'b000010000,
        PH_LEN_LO  = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CK_A    = 9'b010000000,
        PH_CK_B    = 9'b100000000
    } t_phase;

endpackage

`default_nettype wire

>>> rtl/ubx_frame_receiver_top.sv
// ubx frame receiver: each input item passes through the stage-1 register and the output register to its result item
// throughput 1 item per cycle while the output is not stalled, set by the single-port payload buffer (one write
// or one registered read per item) and the registered receiver state update
// synchronous active-low reset clears the receiver, pending flag, overrun count
// and both stages; sync registers return to 0xb5 and 0x62; buffer is not cleared
// depends on ubx_fr_pkg and ubx_frame_receiver_top_assert.svh
`default_nettype none
`include "ubx_frame_receiver_top_assert.svh"

module ubx_frame_receiver_top #(
    parameter int PAYLOAD_BYTES = ubx_fr_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [ubx_fr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ubx_fr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // byte_value, read_index
    input  wire logic [ubx_fr_pkg::S_DATA_W-1:0]   i_s_axis_tdata,
    // req_type
    input  wire logic [ubx_fr_pkg::S_USER_W-1:0]   i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // msg_pending, msg_class, msg_id, msg_length, read_data, overrun_count, zero pad
    output logic [ubx_fr_pkg::M_DATA_W-1:0]        o_m_axis_tdata,
    // frame_status
    output logic [ubx_fr_pkg::M_USER_W-1:0]        o_m_axis_tuser
);

    localparam int AW = $clog2(PAYLOAD_BYTES);
    localparam logic [15:0] MAX_LEN = 16'(PAYLOAD_BYTES);
    localparam logic [8:0]  MAX_IDX = 9'(PAYLOAD_BYTES);

    logic [7:0] r_sync_first;
    logic [7:0] r_sync_second;

    ubx_fr_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_ident, n_ident;
    logic [15:0] r_len, n_len;
    logic [7:0]  r_pos, n_pos;
    logic        r_pending, n_pending;
    logic [7:0]  r_drop, n_drop;

    logic [7:0] r_mem [PAYLOAD_BYTES];
    logic [7:0] r_rd_q;

    logic                r_s1_valid;
    ubx_fr_pkg::t_status r_s1_status;
    logic                r_s1_pending;
    logic [7:0]          r_s1_class;
    logic [7:0]          r_s1_ident;
    logic [7:0]          r_s1_len;
    logic                r_s1_rd;
    logic [7:0]          r_s1_drop;

    logic                          r_out_valid;
    logic [ubx_fr_pkg::M_DATA_W-1:0] r_out_data;
    logic [ubx_fr_pkg::M_USER_W-1:0] r_out_user;

    logic                out_free;
    logic                s1_move;
    logic                s_acc;
    ubx_fr_pkg::t_req    req;
    logic [7:0]          c_byte;
    logic [7:0]          rd_idx;
    logic                rd_ok;
    logic                wr_en;
    logic [7:0]          sa_add;
    logic [7:0]          pos_inc;
    logic [15:0]         len_full;
    ubx_fr_pkg::t_status status;
    logic [7:0]          len_sat;
    logic [7:0]          rd_data;

    assign o_cfg_ready = 1'b1;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign s1_move         = r_s1_valid && out_free;
    assign o_s_axis_tready = !r_s1_valid || out_free;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    assign req    = ubx_fr_pkg::t_req'(i_s_axis_tuser);
    assign c_byte = i_s_axis_tdata[7:0];
    assign rd_idx = i_s_axis_tdata[15:8];
    assign rd_ok  = ({1'b0, rd_idx} < MAX_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= ubx_fr_pkg::SYNC_FIRST_RST;
            r_sync_second <= ubx_fr_pkg::SYNC_SECOND_RST;
        end else if (i_cfg_valid) begin
            if (ubx_fr_pkg::t_cfg_idx'(i_cfg_index) == ubx_fr_pkg::CFG_SYNC_FIRST) begin
                r_sync_first <= i_cfg_data;
            end else begin
                r_sync_second <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_sum_a   = r_sum_a;
        n_sum_b   = r_sum_b;
        n_class   = r_class;
        n_ident   = r_ident;
        n_len     = r_len;
        n_pos     = r_pos;
        n_pending = r_pending;
        n_drop    = r_drop;
        status    = ubx_fr_pkg::ST_NONE;
        wr_en     = 1'b0;
        sa_add    = r_sum_a + c_byte;
        pos_inc   = r_pos + 8'd1;
        len_full  = {c_byte, r_len[7:0]};
        if (s_acc) begin
            case (req)
                ubx_fr_pkg::REQ_BYTE: begin
                    if (r_phase != ubx_fr_pkg::PH_CK_A && r_phase != ubx_fr_pkg::PH_CK_B) begin
                        n_sum_a = sa_add;
                        n_sum_b = r_sum_b + sa_add;
                    end
                    unique case (r_phase)
                        ubx_fr_pkg::PH_HUNT: begin
                            if (c_byte == r_sync_first) begin
                                n_phase = ubx_fr_pkg::PH_SYNC1;
                            end
                        end
                        ubx_fr_pkg::PH_SYNC1: begin
                            if (c_byte != r_sync_second) begin
                                n_phase = ubx_fr_pkg::PH_HUNT;
                                status  = ubx_fr_pkg::ST_ERR;
                            end else begin
                                n_sum_a = 8'd0;
                                n_sum_b = 8'd0;
                                n_phase = ubx_fr_pkg::PH_SYNC2;
                            end
                        end
                        ubx_fr_pkg::PH_SYNC2: begin
                            if (r_pending) begin
                                n_drop  = r_drop + 8'd1;
                                n_phase = ubx_fr_pkg::PH_HUNT;
                                status  = ubx_fr_pkg::ST_DROP;
                            end else begin
                                n_class = c_byte;
                                n_phase = ubx_fr_pkg::PH_CLASS;
                            end
                        end
                        ubx_fr_pkg::PH_CLASS: begin
                            n_ident = c_byte;
                            n_phase = ubx_fr_pkg::PH_ID;
                        end
                        ubx_fr_pkg::PH_ID: begin
                            n_len   = {8'h00, c_byte};
                            n_phase = ubx_fr_pkg::PH_LEN_LO;
                        end
                        ubx_fr_pkg::PH_LEN_LO: begin
                            n_len = len_full;
                            if (len_full > MAX_LEN) begin
                                n_phase = ubx_fr_pkg::PH_HUNT;
                                status  = ubx_fr_pkg::ST_ERR;
                            end else begin
                                n_pos   = 8'd0;
                                n_phase = (len_full == 16'd0) ? ubx_fr_pkg::PH_CK_A
                                                              : ubx_fr_pkg::PH_PAYLOAD;
                            end
                        end
                        ubx_fr_pkg::PH_PAYLOAD: begin
                            wr_en = 1'b1;
                            n_pos = pos_inc;
                            if ({8'h00, pos_inc} >= r_len) begin
                                n_phase = ubx_fr_pkg::PH_CK_A;
                            end
                        end
                        ubx_fr_pkg::PH_CK_A: begin
                            if (c_byte != r_sum_a) begin
                                n_phase = ubx_fr_pkg::PH_HUNT;
                                status  = ubx_fr_pkg::ST_ERR;
                            end else begin
                                n_phase = ubx_fr_pkg::PH_CK_B;
                            end
                        end
                        ubx_fr_pkg::PH_CK_B: begin
                            n_phase = ubx_fr_pkg::PH_HUNT;
                            if (c_byte != r_sum_b) begin
                                status = ubx_fr_pkg::ST_ERR;
                            end else begin
                                n_pending = 1'b1;
                                status    = ubx_fr_pkg::ST_DONE;
                            end
                        end
                        default: begin
                            n_phase = ubx_fr_pkg::PH_HUNT;
                        end
                    endcase
                end
                ubx_fr_pkg::REQ_CLEAR: begin
                    n_pending = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        len_sat = (|n_len[15:8]) ? 8'hFF : n_len[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ubx_fr_pkg::PH_HUNT;
            r_sum_a   <= 8'd0;
            r_sum_b   <= 8'd0;
            r_class   <= 8'd0;
            r_ident   <= 8'd0;
            r_len     <= 16'd0;
            r_pos     <= 8'd0;
            r_pending <= 1'b0;
            r_drop    <= 8'd0;
        end else begin
            r_phase   <= n_phase;
            r_sum_a   <= n_sum_a;
            r_sum_b   <= n_sum_b;
            r_class   <= n_class;
            r_ident   <= n_ident;
            r_len     <= n_len;
            r_pos     <= n_pos;
            r_pending <= n_pending;
            r_drop    <= n_drop;
        end
    end

    // a write lands in the memory before any later read samples it, so no bypass is needed
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pos[AW-1:0]] <= c_byte;
        end
        if (s_acc && req == ubx_fr_pkg::REQ_READ) begin
            r_rd_q <= r_mem[rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_status  <= status;
            r_s1_pending <= n_pending;
            r_s1_class   <= n_class;
            r_s1_ident   <= n_ident;
            r_s1_len     <= len_sat;
            r_s1_rd      <= (req == ubx_fr_pkg::REQ_READ) && rd_ok;
            r_s1_drop    <= n_drop;
        end
    end

    assign rd_data = r_s1_rd ? r_rd_q : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_user <= r_s1_status;
            r_out_data <= {7'd0, r_s1_drop, rd_data, r_s1_len, r_s1_ident, r_s1_class,
                           r_s1_pending};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    `UFR_ASSERT_NXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !out_free,
        r_s1_valid && $stable(r_s1_status), "stalled stage lost its item")
    `UFR_ASSERT_IMP(a_ready_stall, i_clk, i_rst_n, !o_s_axis_tready,
        r_s1_valid && r_out_valid, "input stalled with a free stage")
    `UFR_ASSERT_IMP(a_done_pending, i_clk, i_rst_n,
        r_s1_valid && r_s1_status == ubx_fr_pkg::ST_DONE, r_s1_pending,
        "completed frame without pending flag")
    `UFR_ASSERT_NXT(a_drop_count, i_clk, i_rst_n,
        s_acc && req == ubx_fr_pkg::REQ_BYTE && r_phase == ubx_fr_pkg::PH_SYNC2 && r_pending,
        r_drop == $past(r_drop) + 8'd1, "overrun not counted")

endmodule

`default_nettype wire
